[src/aarm_pkg.sv]
// Shared constants, types and arithmetic helpers for the axis-angle rotation core.
`timescale 1ns / 1ps

package aarm_pkg;

  // Internal fixed point is Q2.30 carried with two guard bits.
  localparam int VW           = 34;
  localparam int FRAC         = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int MAG_W        = 32;
  localparam int NUM_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int QUO_W        = 31;
  localparam int SHIFT_W      = 5;

  typedef logic signed [VW-1:0] val_t;
  typedef logic [VW-1:0]        umag_t;
  typedef logic [2*VW-1:0]      prod_t;

  // 1/K of the rotation sequence, Q2.30.
  localparam val_t CORDIC_K = val_t'(652032874);

  // atan(2^-i) in binary angle units, 2^32 per turn.
  function automatic val_t atan_turn(int i);
    case (i)
      0:       return val_t'(32'h20000000);
      1:       return val_t'(32'h12E4051E);
      2:       return val_t'(32'h09FB385B);
      3:       return val_t'(32'h051111D4);
      4:       return val_t'(32'h028B0D43);
      5:       return val_t'(32'h0145D7E1);
      6:       return val_t'(32'h00A2F61E);
      7:       return val_t'(32'h00517C55);
      8:       return val_t'(32'h0028BE53);
      9:       return val_t'(32'h00145F2F);
      10:      return val_t'(32'h000A2F98);
      11:      return val_t'(32'h000517CC);
      12:      return val_t'(32'h00028BE6);
      13:      return val_t'(32'h000145F3);
      14:      return val_t'(32'h0000A2FA);
      15:      return val_t'(32'h0000517D);
      16:      return val_t'(32'h000028BE);
      17:      return val_t'(32'h0000145F);
      18:      return val_t'(32'h00000A30);
      19:      return val_t'(32'h00000518);
      20:      return val_t'(32'h0000028C);
      21:      return val_t'(32'h00000146);
      22:      return val_t'(32'h000000A3);
      23:      return val_t'(32'h00000051);
      24:      return val_t'(32'h00000029);
      25:      return val_t'(32'h00000014);
      26:      return val_t'(32'h0000000A);
      27:      return val_t'(32'h00000005);
      28:      return val_t'(32'h00000003);
      29:      return val_t'(32'h00000001);
      default: return '0;
    endcase
  endfunction

  function automatic umag_t mag_of(val_t v);
    return v[VW-1] ? umag_t'(-v) : umag_t'(v);
  endfunction

  // Q2.30 product from a magnitude product, rounded half away from zero.
  function automatic val_t round_mul(prod_t p, logic neg);
    prod_t r;
    val_t  m;
    r = (p + (prod_t'(1) << (FRAC - 1))) >> FRAC;
    m = val_t'(r[VW-1:0]);
    return neg ? -m : m;
  endfunction

endpackage

[src/aarm_in_if.sv]
// Input channel: axis components and turn angle with valid/ready.
`timescale 1ns / 1ps

interface aarm_in_if #(
  parameter int AXIS_WIDTH  = 16,
  parameter int ANGLE_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [AXIS_WIDTH-1:0] axis_x;
  logic signed [AXIS_WIDTH-1:0] axis_y;
  logic signed [AXIS_WIDTH-1:0] axis_z;
  logic [ANGLE_WIDTH-1:0]       turn_angle;

  modport source (output valid, axis_x, axis_y, axis_z, turn_angle, input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, turn_angle, output ready);
endinterface

[src/aarm_out_if.sv]
// Result channel: nine matrix entries and the zero-axis flag with valid/ready.
`timescale 1ns / 1ps

interface aarm_out_if #(
  parameter int OUT_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] col0_row0;
  logic signed [OUT_WIDTH-1:0] col0_row1;
  logic signed [OUT_WIDTH-1:0] col0_row2;
  logic signed [OUT_WIDTH-1:0] col1_row0;
  logic signed [OUT_WIDTH-1:0] col1_row1;
  logic signed [OUT_WIDTH-1:0] col1_row2;
  logic signed [OUT_WIDTH-1:0] col2_row0;
  logic signed [OUT_WIDTH-1:0] col2_row1;
  logic signed [OUT_WIDTH-1:0] col2_row2;
  logic                        zero_axis;

  modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                  col1_row2, col2_row0, col2_row1, col2_row2, zero_axis, input ready);
  modport sink   (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                  col1_row2, col2_row0, col2_row1, col2_row2, zero_axis, output ready);
endinterface

[src/aarm_cordic.sv]
// Pipelined rotation-mode CORDIC: binary angle in, cosine and sine out (Q2.30).
`timescale 1ns / 1ps

module aarm_cordic
  import aarm_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output val_t                   cos_o,
  output val_t                   sin_o
);

  val_t x_r [CORDIC_STEPS+1];
  val_t y_r [CORDIC_STEPS+1];
  val_t z_r [CORDIC_STEPS+1];
  val_t cos_r, sin_r;

  logic [31:0] th;
  logic [31:0] th_fold;
  logic        flip;

  // second and third quarter start from -1/K, half a turn taken off
  always_comb begin
    th      = 32'(angle) << (32 - ANGLE_WIDTH);
    flip    = th[31] ^ th[30];
    th_fold = flip ? (th ^ 32'h8000_0000) : th;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0] <= flip ? -CORDIC_K : CORDIC_K;
      y_r[0] <= '0;
      z_r[0] <= val_t'(signed'(th_fold));
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    val_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!z_r[i][VW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= x_r[CORDIC_STEPS];
      sin_r <= y_r[CORDIC_STEPS];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

[src/axis_angle_rotation_matrix_core.sv]
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined.
//
//   channel  dir  handshake     beat contents
//   in_chan  in   valid/ready   axis_x, axis_y, axis_z, turn_angle
//   out_chan out  valid/ready   col0_row0 .. col2_row2, zero_axis
//
// One beat per cycle in and out, except while the pipeline holds for a stalled result.
// Depth is set by the 32-step square root and the 31-step divider on the axis path;
// the 30-step CORDIC runs beside the root.
// Whole pipeline advances together; it holds while the result register is full
// and not taken. Reset clears the valid bits only.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_core
  import aarm_pkg::*;
#(
  parameter int AXIS_WIDTH        = 16,
  parameter int ANGLE_WIDTH       = 16,
  parameter int OUT_FRACTION_BITS = 14
) (
  input logic        clk,
  input logic        rst_n,
  aarm_in_if.sink    in_chan,
  aarm_out_if.source out_chan
);

  localparam int OUT_W = OUT_FRACTION_BITS + 2;
  localparam int SH    = FRAC - OUT_FRACTION_BITS;
  localparam int SUM_W = VW + 2;
  localparam int NST   = 6 + ROOT_W + 1 + QUO_W + 6;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t RND = sum_t'((2 ** SH) / 2);
  localparam sum_t LIM = sum_t'(1) <<< OUT_FRACTION_BITS;
  localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << OUT_FRACTION_BITS;

  typedef struct packed {
    logic [NUM_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0]                  neg;
    logic                        zero;
  } sqs_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0]       rem;
    logic [2:0][QUO_W-1:0]       q;
    logic [ROOT_W-1:0]           len;
    logic [2:0]                  neg;
    logic                        zero;
    val_t                        c;
    val_t                        s;
  } dvs_t;

  function automatic logic [OUT_W-1:0] to_out(sum_t v);
    sum_t m;
    sum_t r;
    m = v[SUM_W-1] ? -v : v;
    m = (m + RND) >> SH;
    r = v[SUM_W-1] ? -m : m;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[OUT_W-1:0];
  endfunction

  // ---------------- flow control
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv           = !vld_r[NST-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_chan.valid};
    end
  end

  // ---------------- front end: magnitude, normalize, sum of squares
  logic signed [AXIS_WIDTH-1:0] f1_a_r [3];
  logic [ANGLE_WIDTH-1:0]       f1_ang_r, f2_ang_r, f3_ang_r, f4_ang_r, f5_ang_r, f6_ang_r;
  logic [2:0][MAG_W-1:0]        f2_mag_r, f3_mag_r, f4_mag_r, f5_mag_r, f6_mag_r;
  logic [2:0]                   f2_neg_r, f3_neg_r, f4_neg_r, f5_neg_r, f6_neg_r;
  logic [MAG_W-1:0]             f2_big_r;
  logic                         f3_zero_r, f4_zero_r, f5_zero_r, f6_zero_r;
  logic [SHIFT_W-1:0]           f3_k_r;
  logic [2:0][NUM_W-1:0]        f5_sq_r;
  logic [NUM_W-1:0]             f6_n_r;

  logic [2:0][MAG_W-1:0]        mag_c;
  logic [MAG_W-1:0]             big_c;
  logic [SHIFT_W-1:0]           msb_c, k_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = MAG_W'(unsigned'(f1_a_r[i][AXIS_WIDTH-1] ? -f1_a_r[i] : f1_a_r[i]));
    end
    big_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    if (mag_c[2] > big_c) big_c = mag_c[2];
  end

  // shift that brings the largest magnitude to [2^30, 2^31)
  always_comb begin
    msb_c = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (f2_big_r[b]) msb_c = SHIFT_W'(b);
    end
    k_c = (msb_c < SHIFT_W'(FRAC)) ? SHIFT_W'(FRAC) - msb_c : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_a_r[0] <= in_chan.axis_x;
      f1_a_r[1] <= in_chan.axis_y;
      f1_a_r[2] <= in_chan.axis_z;
      f1_ang_r  <= in_chan.turn_angle;

      f2_mag_r  <= mag_c;
      f2_big_r  <= big_c;
      f2_neg_r  <= {f1_a_r[2][AXIS_WIDTH-1], f1_a_r[1][AXIS_WIDTH-1], f1_a_r[0][AXIS_WIDTH-1]};
      f2_ang_r  <= f1_ang_r;

      f3_mag_r  <= f2_mag_r;
      f3_k_r    <= k_c;
      f3_zero_r <= (f2_big_r == '0);
      f3_neg_r  <= f2_neg_r;
      f3_ang_r  <= f2_ang_r;

      for (int i = 0; i < 3; i++) begin
        f4_mag_r[i] <= f3_mag_r[i] << f3_k_r;
        f5_sq_r[i]  <= NUM_W'(f4_mag_r[i]) * NUM_W'(f4_mag_r[i]);
      end
      f4_zero_r <= f3_zero_r;
      f4_neg_r  <= f3_neg_r;
      f4_ang_r  <= f3_ang_r;

      f5_mag_r  <= f4_mag_r;
      f5_zero_r <= f4_zero_r;
      f5_neg_r  <= f4_neg_r;
      f5_ang_r  <= f4_ang_r;

      f6_n_r    <= f5_sq_r[0] + f5_sq_r[1] + f5_sq_r[2];
      f6_mag_r  <= f5_mag_r;
      f6_zero_r <= f5_zero_r;
      f6_neg_r  <= f5_neg_r;
      f6_ang_r  <= f5_ang_r;
    end
  end

  // ---------------- sine and cosine, lands beside the last root stage
  val_t cos_c, sin_c;

  aarm_cordic #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_cordic (
    .clk   (clk),
    .adv   (adv),
    .angle (f6_ang_r),
    .cos_o (cos_c),
    .sin_o (sin_c)
  );

  // ---------------- integer square root, one result bit per stage
  sqs_t sq_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    sqs_t              prv;
    sqs_t              sq_nxt;
    logic [NUM_W+1:0]  trial;

    if (j == 0) begin : g_first
      assign prv = '{rem: f6_n_r, root: '0, mag: f6_mag_r, neg: f6_neg_r, zero: f6_zero_r};
    end else begin : g_rest
      assign prv = sq_r[j-1];
    end

    // (root + 2^B)^2 - root^2 against the remainder
    always_comb begin
      sq_nxt = prv;
      trial  = ((NUM_W+2)'(prv.root) << (B + 1)) + ((NUM_W+2)'(1) << (2 * B));
      if ((NUM_W+2)'(prv.rem) >= trial) begin
        sq_nxt.rem  = prv.rem - trial[NUM_W-1:0];
        sq_nxt.root = prv.root | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) sq_r[j] <= sq_nxt;
    end
  end

  // ---------------- divider setup: (mag << 30) + len/2
  dvs_t dp_r;
  dvs_t dp_nxt;

  always_comb begin
    dp_nxt.len  = sq_r[ROOT_W-1].root;
    dp_nxt.neg  = sq_r[ROOT_W-1].neg;
    dp_nxt.zero = sq_r[ROOT_W-1].zero;
    dp_nxt.c    = cos_c;
    dp_nxt.s    = sin_c;
    dp_nxt.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dp_nxt.rem[i] = (NUM_W'(sq_r[ROOT_W-1].mag[i]) << FRAC)
                    + NUM_W'(sq_r[ROOT_W-1].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dp_r <= dp_nxt;
  end

  // ---------------- restoring divide, three lanes, one quotient bit per stage
  dvs_t dv_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int B = QUO_W - 1 - j;
    dvs_t             prv;
    dvs_t             dv_nxt;
    logic [NUM_W-1:0] dsor;

    if (j == 0) begin : g_first
      assign prv = dp_r;
    end else begin : g_rest
      assign prv = dv_r[j-1];
    end

    always_comb begin
      dv_nxt = prv;
      dsor   = NUM_W'(prv.len) << B;
      for (int i = 0; i < 3; i++) begin
        if (prv.rem[i] >= dsor) begin
          dv_nxt.rem[i]  = prv.rem[i] - dsor;
          dv_nxt.q[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) dv_r[j] <= dv_nxt;
    end
  end

  // ---------------- matrix products
  val_t  u_c [3];
  val_t  oc_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = dv_r[QUO_W-1].neg[i] ? -val_t'(dv_r[QUO_W-1].q[i]) : val_t'(dv_r[QUO_W-1].q[i]);
    end
    oc_c = (val_t'(1) <<< FRAC) - dv_r[QUO_W-1].c;
  end

  prod_t m1_poc_r [3];
  prod_t m1_pus_r [3];
  logic  [2:0] m1_noc_r, m1_nus_r;
  val_t  m1_u_r [3];
  val_t  m1_c_r, m2_c_r, m3_c_r, m4_c_r;
  logic  m1_zero_r, m2_zero_r, m3_zero_r, m4_zero_r, m5_zero_r;

  val_t  m2_o_r [3];
  val_t  m2_us_r [3], m3_us_r [3], m4_us_r [3];
  val_t  m2_u_r [3];

  prod_t m3_p_r [6];
  logic  [5:0] m3_n_r;
  val_t  m4_r_r [6];
  sum_t  m5_s_r [9];
  logic  [OUT_W-1:0] m6_o_r [9];
  logic  m6_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // oc*u and u*s
      for (int i = 0; i < 3; i++) begin
        m1_poc_r[i] <= prod_t'(mag_of(oc_c)) * prod_t'(mag_of(u_c[i]));
        m1_noc_r[i] <= oc_c[VW-1] ^ u_c[i][VW-1];
        m1_pus_r[i] <= prod_t'(mag_of(u_c[i])) * prod_t'(mag_of(dv_r[QUO_W-1].s));
        m1_nus_r[i] <= u_c[i][VW-1] ^ dv_r[QUO_W-1].s[VW-1];
        m1_u_r[i]   <= u_c[i];
      end
      m1_c_r    <= dv_r[QUO_W-1].c;
      m1_zero_r <= dv_r[QUO_W-1].zero;

      for (int i = 0; i < 3; i++) begin
        m2_o_r[i]  <= round_mul(m1_poc_r[i], m1_noc_r[i]);
        m2_us_r[i] <= round_mul(m1_pus_r[i], m1_nus_r[i]);
        m2_u_r[i]  <= m1_u_r[i];
      end
      m2_c_r    <= m1_c_r;
      m2_zero_r <= m1_zero_r;

      // ox*x, ox*y, oz*x, oy*y, oy*z, oz*z
      m3_p_r[0] <= prod_t'(mag_of(m2_o_r[0])) * prod_t'(mag_of(m2_u_r[0]));
      m3_n_r[0] <= m2_o_r[0][VW-1] ^ m2_u_r[0][VW-1];
      m3_p_r[1] <= prod_t'(mag_of(m2_o_r[0])) * prod_t'(mag_of(m2_u_r[1]));
      m3_n_r[1] <= m2_o_r[0][VW-1] ^ m2_u_r[1][VW-1];
      m3_p_r[2] <= prod_t'(mag_of(m2_o_r[2])) * prod_t'(mag_of(m2_u_r[0]));
      m3_n_r[2] <= m2_o_r[2][VW-1] ^ m2_u_r[0][VW-1];
      m3_p_r[3] <= prod_t'(mag_of(m2_o_r[1])) * prod_t'(mag_of(m2_u_r[1]));
      m3_n_r[3] <= m2_o_r[1][VW-1] ^ m2_u_r[1][VW-1];
      m3_p_r[4] <= prod_t'(mag_of(m2_o_r[1])) * prod_t'(mag_of(m2_u_r[2]));
      m3_n_r[4] <= m2_o_r[1][VW-1] ^ m2_u_r[2][VW-1];
      m3_p_r[5] <= prod_t'(mag_of(m2_o_r[2])) * prod_t'(mag_of(m2_u_r[2]));
      m3_n_r[5] <= m2_o_r[2][VW-1] ^ m2_u_r[2][VW-1];
      m3_us_r   <= m2_us_r;
      m3_c_r    <= m2_c_r;
      m3_zero_r <= m2_zero_r;

      for (int i = 0; i < 6; i++) begin
        m4_r_r[i] <= round_mul(m3_p_r[i], m3_n_r[i]);
      end
      m4_us_r   <= m3_us_r;
      m4_c_r    <= m3_c_r;
      m4_zero_r <= m3_zero_r;

      // column-major entries; us = x*s, y*s, z*s
      m5_s_r[0] <= sum_t'(m4_r_r[0]) + sum_t'(m4_c_r);
      m5_s_r[1] <= sum_t'(m4_r_r[1]) - sum_t'(m4_us_r[2]);
      m5_s_r[2] <= sum_t'(m4_r_r[2]) + sum_t'(m4_us_r[1]);
      m5_s_r[3] <= sum_t'(m4_r_r[1]) + sum_t'(m4_us_r[2]);
      m5_s_r[4] <= sum_t'(m4_r_r[3]) + sum_t'(m4_c_r);
      m5_s_r[5] <= sum_t'(m4_r_r[4]) - sum_t'(m4_us_r[0]);
      m5_s_r[6] <= sum_t'(m4_r_r[2]) - sum_t'(m4_us_r[1]);
      m5_s_r[7] <= sum_t'(m4_r_r[4]) + sum_t'(m4_us_r[0]);
      m5_s_r[8] <= sum_t'(m4_r_r[5]) + sum_t'(m4_c_r);
      m5_zero_r <= m4_zero_r;

      // zero axis forces the identity
      for (int i = 0; i < 9; i++) begin
        if (m5_zero_r) begin
          m6_o_r[i] <= (i % 4 == 0) ? ONE_OUT : '0;
        end else begin
          m6_o_r[i] <= to_out(m5_s_r[i]);
        end
      end
      m6_zero_r <= m5_zero_r;
    end
  end

  assign out_chan.valid     = vld_r[NST-1];
  assign out_chan.col0_row0 = m6_o_r[0];
  assign out_chan.col0_row1 = m6_o_r[1];
  assign out_chan.col0_row2 = m6_o_r[2];
  assign out_chan.col1_row0 = m6_o_r[3];
  assign out_chan.col1_row1 = m6_o_r[4];
  assign out_chan.col1_row2 = m6_o_r[5];
  assign out_chan.col2_row0 = m6_o_r[6];
  assign out_chan.col2_row1 = m6_o_r[7];
  assign out_chan.col2_row2 = m6_o_r[8];
  assign out_chan.zero_axis = m6_zero_r;

endmodule

[src/aarm_checker.sv]
// Port-level assertions for the rotation core, bound to the top level.
`timescale 1ns / 1ps

module aarm_checker #(
  parameter int OUT_FRACTION_BITS = 14
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [OUT_FRACTION_BITS+1:0]  m00,
  input logic signed [OUT_FRACTION_BITS+1:0]  m01,
  input logic signed [OUT_FRACTION_BITS+1:0]  m02,
  input logic signed [OUT_FRACTION_BITS+1:0]  m10,
  input logic signed [OUT_FRACTION_BITS+1:0]  m11,
  input logic signed [OUT_FRACTION_BITS+1:0]  m12,
  input logic signed [OUT_FRACTION_BITS+1:0]  m20,
  input logic signed [OUT_FRACTION_BITS+1:0]  m21,
  input logic signed [OUT_FRACTION_BITS+1:0]  m22,
  input logic                                 zero_axis
);

  localparam int OW = OUT_FRACTION_BITS + 2;
  localparam logic signed [OW-1:0] ONE  = OW'(1) << OUT_FRACTION_BITS;
  localparam logic signed [OW-1:0] MONE = -ONE;

  // reset empties the pipeline
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && zero_axis |->
        m00 == ONE && m11 == ONE && m22 == ONE && m01 == 0 && m02 == 0 &&
        m10 == 0 && m12 == 0 && m20 == 0 && m21 == 0)
    else $error("zero axis without identity matrix");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |->
        m00 <= ONE && m00 >= MONE && m11 <= ONE && m11 >= MONE &&
        m22 <= ONE && m22 >= MONE && m01 <= ONE && m01 >= MONE)
    else $error("matrix entry beyond unit range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=>
        out_valid && $stable(m00) && $stable(m11) && $stable(m22) &&
        $stable(m01) && $stable(zero_axis))
    else $error("stalled result beat changed");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker #(
  .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
) u_aarm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .m00       (out_chan.col0_row0),
  .m01       (out_chan.col0_row1),
  .m02       (out_chan.col0_row2),
  .m10       (out_chan.col1_row0),
  .m11       (out_chan.col1_row1),
  .m12       (out_chan.col1_row2),
  .m20       (out_chan.col2_row0),
  .m21       (out_chan.col2_row1),
  .m22       (out_chan.col2_row2),
  .zero_axis (out_chan.zero_axis)
);
